// ===== design/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdd_pkg
// shared widths, constants and register codes of the proximity dwell detector
// ----------------------------------------------------------------------------
package pdd_pkg;

    localparam int TAG_COUNT = 4;
    localparam int TAG_W     = 2;
    localparam int DIST_W    = 16;
    localparam int SUM_W     = DIST_W + 2;
    localparam int HIT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [HIT_W-1:0]  t_hit;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_LIMIT  = 2'd0,
        CFG_STILL_LIMIT = 2'd1,
        CFG_HOLD_TICKS  = 2'd2,
        CFG_COUNT_NEED  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_TICK   = 1'b1
    } t_func;

    localparam t_dist RST_NEAR_LIMIT  = 16'd1200;
    localparam t_dist RST_STILL_LIMIT = 16'd10;
    localparam t_dist RST_HOLD_TICKS  = 16'd100;
    localparam t_hit  RST_COUNT_NEED  = 3'd3;

endpackage

// ===== design/pdd_in_if.sv =====
// ----------------------------------------------------------------------------
// pdd_in_if
// input channel: distance samples and time ticks
// ----------------------------------------------------------------------------
interface pdd_in_if;
    import pdd_pkg::*;

    logic  valid;
    logic  ready;
    logic  func;
    t_tag  tag_id;
    t_dist distance_mm;

    modport source (output valid, output func, output tag_id, output distance_mm,
                    input ready);
    modport sink   (input valid, input func, input tag_id, input distance_mm,
                    output ready);
endinterface

// ===== design/pdd_out_if.sv =====
// ----------------------------------------------------------------------------
// pdd_out_if
// result channel: access decision, hold-off status and average distance
// ----------------------------------------------------------------------------
interface pdd_out_if;
    import pdd_pkg::*;

    logic  valid;
    logic  ready;
    logic  access_granted;
    logic  hold_active;
    t_dist average_mm;

    modport source (output valid, output access_granted, output hold_active,
                    output average_mm, input ready);
    modport sink   (input valid, input access_granted, input hold_active,
                    input average_mm, output ready);
endinterface

// ===== design/proximity_dwell_detector_core.sv =====
// ----------------------------------------------------------------------------
// proximity_dwell_detector_core
// per-tag four-sample averaging, speed estimate and dwell-based access grant
// ----------------------------------------------------------------------------
// a result passes the input register and then the result register
// throughput: one item per cycle while the output is not stalled, input register and result register in line
// ready stays high while the result register drains or is empty
// reset (synchronous, active low) clears tag histories, hit counters,
// the hold-off counter, pipeline valids and loads the register defaults
module proximity_dwell_detector_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pdd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    pdd_in_if.sink                    i_in,
    pdd_out_if.source                 o_out
);
    import pdd_pkg::*;

    // configuration registers
    t_dist r_near_limit;
    t_dist r_still_limit;
    t_dist r_hold_ticks;
    t_hit  r_count_need;

    // input register
    logic  r_in_valid;
    logic  r_in_func;
    t_tag  r_in_tag;
    t_dist r_in_dist;

    // per-tag history and hit counters
    t_dist r_dist1 [TAG_COUNT];
    t_dist r_dist2 [TAG_COUNT];
    t_dist r_dist3 [TAG_COUNT];
    t_sum  r_sum1  [TAG_COUNT];
    t_sum  r_sum2  [TAG_COUNT];
    t_sum  r_sum3  [TAG_COUNT];
    t_hit  r_hit   [TAG_COUNT];
    t_dist r_holdoff;

    // result register
    logic  r_out_valid;
    logic  r_out_grant;
    logic  r_out_hold;
    t_dist r_out_avg;

    logic  advance;
    logic  in_xfer;
    logic  tag_ok;
    logic  is_sample;
    t_sum  sum;
    t_sum  diff;
    logic  near;
    logic  still;
    t_hit  hit_inc;
    t_hit  n_hit;
    t_dist n_holdoff;
    logic  n_grant;
    t_dist n_avg;

    // the compute stage moves on when the result register is free or draining
    assign advance   = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer   = i_in.valid && i_in.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.access_granted = r_out_grant;
    assign o_out.hold_active    = r_out_hold;
    assign o_out.average_mm     = r_out_avg;

    // ---------------------------------------------------------------
    // decision logic for the item in the input register
    // ---------------------------------------------------------------
    always_comb begin
        tag_ok    = 32'(r_in_tag) < TAG_COUNT;
        is_sample = (r_in_func == FUNC_SAMPLE) && tag_ok;

        // exact four-sample sum, 18 bits never overflows
        sum  = SUM_W'(r_in_dist) + SUM_W'(r_dist1[r_in_tag])
             + SUM_W'(r_dist2[r_in_tag]) + SUM_W'(r_dist3[r_in_tag]);
        diff = (sum >= r_sum3[r_in_tag]) ? sum - r_sum3[r_in_tag]
                                         : r_sum3[r_in_tag] - sum;

        // average < near is sum < 4*near, speed < still is diff < 8*still
        near  = sum < {r_near_limit, 2'b00};
        still = {1'b0, diff} < {r_still_limit, 3'b000};

        hit_inc   = r_hit[r_in_tag] + 3'd1;
        n_hit     = r_hit[r_in_tag];
        n_holdoff = r_holdoff;
        n_grant   = 1'b0;
        n_avg     = '0;

        if (r_in_func == FUNC_TICK) begin
            if (r_holdoff != '0) begin
                n_holdoff = r_holdoff - 16'd1;
            end
        end else if (tag_ok) begin
            n_avg = sum[SUM_W-1:2];
            // decision only when no hold-off runs and the tag is near
            if (r_holdoff == '0 && near) begin
                if (still) begin
                    if (hit_inc == r_count_need) begin
                        n_hit   = '0;
                        n_grant = 1'b1;
                    end else begin
                        n_hit     = hit_inc;
                        n_holdoff = r_hold_ticks;
                    end
                end else begin
                    // near but moving loses its hits
                    n_hit = '0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // configuration, pipeline and state registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit  <= RST_NEAR_LIMIT;
            r_still_limit <= RST_STILL_LIMIT;
            r_hold_ticks  <= RST_HOLD_TICKS;
            r_count_need  <= RST_COUNT_NEED;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NEAR_LIMIT:  r_near_limit  <= i_cfg_data;
                CFG_STILL_LIMIT: r_still_limit <= i_cfg_data;
                CFG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                CFG_COUNT_NEED:  r_count_need  <= i_cfg_data[HIT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, payload loads on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (in_xfer) begin
            r_in_func <= i_in.func;
            r_in_tag  <= i_in.tag_id;
            r_in_dist <= i_in.distance_mm;
        end
    end

    // tag state updates when the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAG_COUNT; t++) begin
                r_dist1[t] <= '0;
                r_dist2[t] <= '0;
                r_dist3[t] <= '0;
                r_sum1[t]  <= '0;
                r_sum2[t]  <= '0;
                r_sum3[t]  <= '0;
                r_hit[t]   <= '0;
            end
            r_holdoff <= '0;
        end else if (r_in_valid && advance) begin
            r_holdoff <= n_holdoff;
            if (is_sample) begin
                r_dist3[r_in_tag] <= r_dist2[r_in_tag];
                r_dist2[r_in_tag] <= r_dist1[r_in_tag];
                r_dist1[r_in_tag] <= r_in_dist;
                r_sum3[r_in_tag]  <= r_sum2[r_in_tag];
                r_sum2[r_in_tag]  <= r_sum1[r_in_tag];
                r_sum1[r_in_tag]  <= sum;
                r_hit[r_in_tag]   <= n_hit;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out_grant <= n_grant;
            r_out_hold  <= n_holdoff != '0;
            r_out_avg   <= n_avg;
        end
    end

endmodule

// ===== design/pdd_checker.sv =====
// ----------------------------------------------------------------------------
// pdd_checker
// port-level checks of the proximity dwell detector, bound to the core module
// ----------------------------------------------------------------------------
module pdd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_grant,
    input logic        i_out_hold,
    input logic [15:0] i_out_avg
);
    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_grant) && $stable(i_out_hold)
            && $stable(i_out_avg))
        else $error("stalled result changed");

    // a grant is only decided with no hold-off running, and it starts none
    a_grant_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_grant |-> !i_out_hold)
        else $error("grant reported with hold-off active");

    // every transfer is followed by a valid result, its own or earlier results that block it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("result missing after input transfer");

    // an empty pipeline always takes input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(!(i_in_valid && i_in_ready))
            |-> i_in_ready)
        else $error("input blocked while pipeline empty");
endmodule

bind proximity_dwell_detector_core pdd_checker u_pdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_grant (o_out.access_granted),
    .i_out_hold  (o_out.hold_active),
    .i_out_avg   (o_out.average_mm)
);
